// ===== hw/rtl/u8seg_pkg.sv =====
package u8seg_pkg;

  // Replacement character U+FFFD as EF BF BD, first byte in the low octet
  localparam logic [31:0] REPL_BYTES = 32'h00BD_BFEF;
  localparam logic [2:0]  REPL_LEN   = 3'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } u8seg_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take the incoming byte into the window
    logic advance;  // emit the front group and drop it, or replace and drop its lead
    logic flush;    // emit the truncation replacement and empty the window
  } u8seg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic brk;         // window empty or front group still incomplete
    logic flush_need;  // string ended with bytes left in the window
    logic step_last;   // the group emitted now ends the run
  } u8seg_sts_t;

  // Group length from the lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & 8'h80) == 8'h00) begin
      len = 3'd1;
    end else if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/u8seg_ctrl.sv =====
module u8seg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8seg_pkg::u8seg_sts_t sts,
  output u8seg_pkg::u8seg_cmd_t cmd
);
  import u8seg_pkg::*;

  u8seg_state_t state_r;
  u8seg_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Emit one group per cycle while the output slot is free
        if (sts.slot_free) begin
          if (!sts.brk) begin
            cmd.advance = 1'b1;
            if (sts.step_last) begin
              state_nxt = ST_IDLE;
            end
          end else if (sts.flush_need) begin
            cmd.flush = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/u8seg_dp.sv =====
module u8seg_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u8seg_pkg::u8seg_cmd_t cmd,
  output u8seg_pkg::u8seg_sts_t sts,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_string,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_group_bytes,
  output logic [2:0]            out_group_length,
  output logic                  out_replaced,
  output logic                  out_last_of_run,
  output logic                  out_string_done
);
  import u8seg_pkg::*;

  logic [3:0][7:0] win_r;
  logic [3:0][7:0] win_nxt;
  logic [2:0]      fill_r;
  logic [2:0]      fill_nxt;
  logic            eos_r;
  logic            eos_nxt;

  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [31:0]     bytes_r;
  logic [31:0]     bytes_nxt;
  logic [2:0]      len_r;
  logic [2:0]      len_nxt;
  logic            rep_r;
  logic            rep_nxt;
  logic            last_r;
  logic            last_nxt;
  logic            done_r;
  logic            done_nxt;

  logic [2:0]      len0;
  logic            cont_ok;
  logic            grp_ok;
  logic [2:0]      drop;
  logic [2:0]      fill_left;
  logic [3:0][7:0] shifted;
  logic [2:0]      len_next;
  logic            brk_next;
  logic [31:0]     packed_grp;

  // Examine the group at the window front
  always_comb begin
    len0    = lead_len(win_r[0]);
    cont_ok = 1'b1;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < len0 && (win_r[k] & 8'hC0) != 8'h80) begin
        cont_ok = 1'b0;
      end
    end
    grp_ok = (len0 != 3'd0) && cont_ok;
    drop   = grp_ok ? len0 : 3'd1;
    for (int k = 0; k < 4; k++) begin
      packed_grp[8*k +: 8] = (3'(k) < len0) ? win_r[k] : 8'h00;
    end
  end

  // Window after dropping the emitted bytes, and look at what follows
  always_comb begin
    fill_left = fill_r - drop;
    case (drop)
      3'd1:    shifted = {win_r[3], win_r[3], win_r[2], win_r[1]};
      3'd2:    shifted = {win_r[3], win_r[2], win_r[3], win_r[2]};
      3'd3:    shifted = {win_r[3], win_r[3], win_r[3], win_r[3]};
      default: shifted = win_r;
    endcase
    len_next = lead_len(shifted[0]);
    brk_next = (fill_left == 3'd0) || (len_next != 3'd0 && fill_left < len_next);
  end

  assign sts.slot_free  = !out_valid_r || !out_stall;
  assign sts.brk        = (fill_r == 3'd0) || (len0 != 3'd0 && fill_r < len0);
  assign sts.flush_need = eos_r && (fill_r != 3'd0);
  assign sts.step_last  = brk_next && !(eos_r && fill_left != 3'd0);

  // Window and output register updates
  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r && out_stall;
    bytes_nxt     = bytes_r;
    len_nxt       = len_r;
    rep_nxt       = rep_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (cmd.load) begin
      win_nxt[fill_r[1:0]] = in_data_byte;
      fill_nxt             = fill_r + 3'd1;
      eos_nxt              = in_end_of_string;
    end
    if (cmd.advance) begin
      win_nxt       = shifted;
      fill_nxt      = fill_left;
      out_valid_nxt = 1'b1;
      bytes_nxt     = grp_ok ? packed_grp : REPL_BYTES;
      len_nxt       = grp_ok ? len0 : REPL_LEN;
      rep_nxt       = !grp_ok;
      last_nxt      = sts.step_last;
      done_nxt      = sts.step_last && eos_r;
    end
    if (cmd.flush) begin
      fill_nxt      = 3'd0;
      out_valid_nxt = 1'b1;
      bytes_nxt     = REPL_BYTES;
      len_nxt       = REPL_LEN;
      rep_nxt       = 1'b1;
      last_nxt      = 1'b1;
      done_nxt      = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 3'd0;
      eos_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      eos_r       <= eos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    bytes_r <= bytes_nxt;
    len_r   <= len_nxt;
    rep_r   <= rep_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_group_bytes  = bytes_r;
  assign out_group_length = len_r;
  assign out_replaced     = rep_r;
  assign out_last_of_run  = last_r;
  assign out_string_done  = done_r;

endmodule

// ===== hw/rtl/utf8_codepoint_segmenter.sv =====
// Splits a byte string into UTF-8 code point groups, one request per byte.
// A lead byte sets the group length; once the group is buffered, its
// continuation bytes are checked and it is emitted, or U+FFFD (EF BF BD)
// replaces its lead and the remaining bytes are scanned again. An invalid
// lead gives one U+FFFD; a group cut short by end_of_string gives one U+FFFD
// and its bytes are dropped. Overlong and surrogate forms pass unchecked.
// A byte is accepted and then the window scan emits one group per cycle
// into a single output register while that register is free, and the
// next byte is taken once the scan has finished.
module utf8_codepoint_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_group_bytes,
  output logic [2:0]  out_group_length,
  output logic        out_replaced,
  output logic        out_last_of_run,
  output logic        out_string_done
);
  import u8seg_pkg::*;

  u8seg_cmd_t cmd;
  u8seg_sts_t sts;

  // Sequence the window scan
  u8seg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the window and the output register
  u8seg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_group_bytes  (out_group_bytes),
    .out_group_length (out_group_length),
    .out_replaced     (out_replaced),
    .out_last_of_run  (out_last_of_run),
    .out_string_done  (out_string_done)
  );

endmodule

// ===== hw/rtl/u8seg_checker.sv =====
module u8seg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_group_bytes,
  input logic [2:0]  out_group_length,
  input logic        out_replaced,
  input logic        out_last_of_run,
  input logic        out_string_done
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A replacement is always EF BF BD, three bytes long
  a_repl_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |->
      out_group_bytes == 32'h00BD_BFEF && out_group_length == 3'd3)
    else $error("malformed replacement group");

  // The end of a string always closes the run of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_last_of_run)
    else $error("string end without end of run");

  // Group length stays within one to four bytes
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_group_length != 3'd0 && out_group_length <= 3'd4)
    else $error("group length out of range");

endmodule

bind utf8_codepoint_segmenter u8seg_checker u_u8seg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_group_bytes  (out_group_bytes),
  .out_group_length (out_group_length),
  .out_replaced     (out_replaced),
  .out_last_of_run  (out_last_of_run),
  .out_string_done  (out_string_done)
);
